### hdl/fir_filter_programmable_assert.svh
// ----------------------------------------------------------------------------
// FIR filter assertion macros
// Shared property macros for the concurrent checks in the filter modules.
// ----------------------------------------------------------------------------
`ifndef FIR_FILTER_PROGRAMMABLE_ASSERT_SVH
`define FIR_FILTER_PROGRAMMABLE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define FIR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FIR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hdl/fir_pkg.sv
// ----------------------------------------------------------------------------
// FIR filter package
// Widths, item codes, register map and shared types of the FIR filter.
// ----------------------------------------------------------------------------
package fir_pkg;

  // Default build parameters.
  localparam int DEF_TAPS         = 16;
  localparam int DEF_SAMPLE_WIDTH = 16;

  // Fixed field widths.
  localparam int MODE_W      = 2;
  localparam int COEF_IDX_W  = 4;
  localparam int TAP_CNT_W   = 5;
  localparam int APB_ADDR_W  = 3;
  localparam int APB_DATA_W  = 32;

  // Item codes carried in the mode field.
  localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_COEF  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  // Register map: index taken from the word address bit.
  localparam logic REG_TAP_COUNT = 1'b0;

  localparam logic [TAP_CNT_W-1:0] TAP_CNT_RESET = 5'd16;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_FLUSH
  } state_e;

  // Control that travels with the memory read data into the MAC.
  typedef struct packed {
    logic clr;
    logic vld;
    logic last;
  } mac_ctl_t;

endpackage

### hdl/fir_ram.sv
// ----------------------------------------------------------------------------
// FIR generic RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module fir_ram #(
  parameter int Width = 16,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/fir_mac.sv
// ----------------------------------------------------------------------------
// FIR multiply-accumulate unit
// Registered product, accumulator, and rounding with saturation of the sum.
// ----------------------------------------------------------------------------
`include "fir_filter_programmable_assert.svh"

module fir_mac #(
  parameter int TAPS         = fir_pkg::DEF_TAPS,
  parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  fir_pkg::mac_ctl_t        ctl_i,
  input  logic [SAMPLE_WIDTH-1:0]  sample_i,
  input  logic [SAMPLE_WIDTH-1:0]  coef_i,
  output logic                     done_o,
  output logic [SAMPLE_WIDTH-1:0]  filtered_o,
  output logic                     saturated_o
);

  localparam int ProdW = 2 * SAMPLE_WIDTH;
  localparam int FullW = ProdW + $clog2(TAPS) + 1;
  localparam int AccW  = (FullW > 64) ? 64 : FullW;
  localparam logic [AccW-1:0] Rnd = AccW'(64'd1 << (SAMPLE_WIDTH - 2));
  localparam logic [SAMPLE_WIDTH-1:0] MaxVal = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] MinVal = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic signed [ProdW-1:0] prod_q;
  logic                    prod_v_q;
  logic                    prod_last_q;
  logic signed [AccW-1:0]  acc_q;
  logic                    done_q;

  logic [AccW-1:0]           sum_w;
  logic [AccW-ProdW+1:0]     upper_w;
  logic                      fits_w;

  // Product stage: one tap per cycle.
  always_ff @(posedge clk_i) begin
    prod_q <= $signed(sample_i) * $signed(coef_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_v_q    <= 1'b0;
      prod_last_q <= 1'b0;
    end else begin
      prod_v_q    <= ctl_i.vld;
      prod_last_q <= ctl_i.vld && ctl_i.last;
    end
  end

  // Accumulator, cleared when a sample transfer starts a new sum.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else if (ctl_i.clr) begin
      acc_q  <= '0;
      done_q <= 1'b0;
    end else if (prod_v_q) begin
      acc_q  <= acc_q + AccW'(prod_q);
      done_q <= prod_last_q;
    end
  end

  // Round half up, drop the fraction bits and clip to the sample range.
  always_comb begin
    sum_w   = acc_q + Rnd;
    upper_w = sum_w[AccW-1:ProdW-2];
    fits_w  = (&upper_w) || !(|upper_w);
    if (fits_w) begin
      filtered_o = sum_w[ProdW-2:SAMPLE_WIDTH-1];
    end else if (sum_w[AccW-1]) begin
      filtered_o = MinVal;
    end else begin
      filtered_o = MaxVal;
    end
    saturated_o = !fits_w;
  end

  assign done_o = done_q;

  `FIR_ASSERT_NXT(a_done_holds, done_q && !ctl_i.clr, done_q, "MAC done dropped without clear")
  `FIR_ASSERT_IMP(a_no_prod_after_done, prod_v_q, !done_q, "Product arrived after sum was done")

endmodule

### hdl/fir_filter_programmable.sv
// Every transfer is accepted only while the sequencer is idle. A sample
// transfer stalls the input until its result, a sum over the n samples held
// after the push (1 to tap_count, clamped to 1..TAPS), is loaded into the
// result register. While issuing, the single read port of the history memory
// feeds one multiply-accumulate per cycle. Reset clears the history, all
// coefficients (through per-entry valid bits) and sets tap_count to 16.
// ----------------------------------------------------------------------------
// Programmable FIR filter
// Direct-form FIR with a circular sample history and a coefficient table in
// RAM, an APB register for the tap count, and a registered result output.
// ----------------------------------------------------------------------------
`include "fir_filter_programmable_assert.svh"

module fir_filter_programmable #(
  parameter int TAPS         = fir_pkg::DEF_TAPS,
  parameter int SAMPLE_WIDTH = fir_pkg::DEF_SAMPLE_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration port
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fir_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [fir_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [fir_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready,
  // Input channel
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [fir_pkg::MODE_W-1:0]      mode_i,
  input  logic [SAMPLE_WIDTH-1:0]         sample_in_i,
  input  logic [fir_pkg::COEF_IDX_W-1:0]  coef_index_i,
  input  logic [SAMPLE_WIDTH-1:0]         coef_value_i,
  // Output channel
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [SAMPLE_WIDTH-1:0]         filtered_o,
  output logic                            saturated_o
);

  localparam int AddrW = (TAPS > 1) ? $clog2(TAPS) : 1;
  localparam int CntW  = $clog2(TAPS + 1);

  fir_pkg::state_e state_q, state_d;

  logic [fir_pkg::TAP_CNT_W-1:0] tap_count_q;
  logic [CntW-1:0]               fill_q;
  logic [AddrW-1:0]              wp_q;
  logic [AddrW-1:0]              cnt_q;
  logic [AddrW-1:0]              raddr_q;
  logic [TAPS-1:0]               coef_vld_q;
  logic                          rd_v_q;
  logic                          rd_last_q;
  logic                          coef_ok_q;
  logic                          out_valid_q;
  logic [SAMPLE_WIDTH-1:0]       filtered_q;
  logic                          sat_q;

  logic                    in_acc;
  logic                    is_push;
  logic                    is_coef;
  logic                    is_clear;
  logic                    coef_idx_ok;
  logic                    cfg_wr;
  logic [CntW-1:0]         n_taps;
  logic [AddrW-1:0]        wp_inc;
  logic [CntW:0]           fill_inc;
  logic [CntW-1:0]         fill_new;
  logic [CntW:0]           base_w;
  logic [AddrW-1:0]        raddr_inc;
  logic                    issue_last;
  logic                    issue;
  logic                    out_free;
  logic                    out_load;

  logic [SAMPLE_WIDTH-1:0] hist_rdata;
  logic [SAMPLE_WIDTH-1:0] coef_rdata;
  logic [SAMPLE_WIDTH-1:0] coef_eff;
  logic                    mac_done;
  logic [SAMPLE_WIDTH-1:0] mac_filtered;
  logic                    mac_sat;
  fir_pkg::mac_ctl_t       mac_ctl;

  // Configuration register access.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == fir_pkg::REG_TAP_COUNT);
  assign prdata = (paddr[2] == fir_pkg::REG_TAP_COUNT) ?
                  fir_pkg::APB_DATA_W'(tap_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_count_q <= fir_pkg::TAP_CNT_RESET;
    end else if (cfg_wr) begin
      tap_count_q <= pwdata[fir_pkg::TAP_CNT_W-1:0];
    end
  end

  // Input decode.
  assign in_stall_o  = (state_q != fir_pkg::ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign is_push     = in_acc && (mode_i == fir_pkg::MODE_PUSH);
  assign is_coef     = in_acc && (mode_i == fir_pkg::MODE_COEF);
  assign is_clear    = in_acc && (mode_i == fir_pkg::MODE_CLEAR);
  assign coef_idx_ok = (32'(coef_index_i) < TAPS);

  // Taps in use, history fill after a push and the oldest held entry.
  always_comb begin
    if (tap_count_q == '0) begin
      n_taps = CntW'(1);
    end else if (32'(tap_count_q) > TAPS) begin
      n_taps = CntW'(TAPS);
    end else begin
      n_taps = CntW'(tap_count_q);
    end
    wp_inc   = (wp_q == AddrW'(TAPS - 1)) ? '0 : wp_q + AddrW'(1);
    fill_inc = (CntW+1)'(fill_q) + (CntW+1)'(1);
    fill_new = (fill_inc > (CntW+1)'(n_taps)) ? n_taps : CntW'(fill_inc);
    if ((CntW+1)'(wp_inc) >= (CntW+1)'(fill_new)) begin
      base_w = (CntW+1)'(wp_inc) - (CntW+1)'(fill_new);
    end else begin
      base_w = (CntW+1)'(wp_inc) + (CntW+1)'(TAPS) - (CntW+1)'(fill_new);
    end
    raddr_inc  = (raddr_q == AddrW'(TAPS - 1)) ? '0 : raddr_q + AddrW'(1);
    issue_last = ((CntW'(cnt_q) + CntW'(1)) == fill_q);
  end

  // Sequencer next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fir_pkg::ST_IDLE: begin
        if (is_push) begin
          state_d = fir_pkg::ST_ISSUE;
        end
      end
      fir_pkg::ST_ISSUE: begin
        if (issue_last) begin
          state_d = fir_pkg::ST_FLUSH;
        end
      end
      fir_pkg::ST_FLUSH: begin
        if (mac_done && out_free) begin
          state_d = fir_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = fir_pkg::ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    issue    = 1'b0;
    out_load = 1'b0;
    unique case (state_q)
      fir_pkg::ST_IDLE: begin
        issue = 1'b0;
      end
      fir_pkg::ST_ISSUE: begin
        issue = 1'b1;
      end
      fir_pkg::ST_FLUSH: begin
        out_load = mac_done && out_free;
      end
      default: begin
        issue = 1'b0;
      end
    endcase
  end

  // Control registers: sequencer state, history pointers, tap counter, coefficient valid bits and output valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= fir_pkg::ST_IDLE;
      fill_q      <= '0;
      wp_q        <= '0;
      cnt_q       <= '0;
      raddr_q     <= '0;
      coef_vld_q  <= '0;
      rd_v_q      <= 1'b0;
      rd_last_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_v_q    <= issue;
      rd_last_q <= issue && issue_last;
      if (is_clear) begin
        fill_q <= '0;
      end
      if (is_push) begin
        fill_q  <= fill_new;
        wp_q    <= wp_inc;
        cnt_q   <= '0;
        raddr_q <= AddrW'(base_w);
      end else if (issue) begin
        cnt_q   <= cnt_q + AddrW'(1);
        raddr_q <= raddr_inc;
      end
      if (is_coef && coef_idx_ok) begin
        coef_vld_q[AddrW'(coef_index_i)] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A coefficient slot never written reads as zero.
  always_ff @(posedge clk_i) begin
    coef_ok_q <= coef_vld_q[cnt_q];
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_q <= mac_filtered;
      sat_q      <= mac_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign saturated_o = sat_q;

  // Sample history, circular, written at the push transfer.
  fir_ram #(
    .Width (SAMPLE_WIDTH),
    .Depth (TAPS)
  ) u_hist_ram (
    .clk_i   (clk_i),
    .we_i    (is_push),
    .waddr_i (wp_q),
    .wdata_i (sample_in_i),
    .re_i    (issue),
    .raddr_i (raddr_q),
    .rdata_o (hist_rdata)
  );

  // Coefficient table.
  fir_ram #(
    .Width (SAMPLE_WIDTH),
    .Depth (TAPS)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (is_coef && coef_idx_ok),
    .waddr_i (AddrW'(coef_index_i)),
    .wdata_i (coef_value_i),
    .re_i    (issue),
    .raddr_i (cnt_q),
    .rdata_o (coef_rdata)
  );

  assign coef_eff     = coef_ok_q ? coef_rdata : '0;
  assign mac_ctl.clr  = is_push;
  assign mac_ctl.vld  = rd_v_q;
  assign mac_ctl.last = rd_last_q;

  fir_mac #(
    .TAPS         (TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mac (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (mac_ctl),
    .sample_i    (hist_rdata),
    .coef_i      (coef_eff),
    .done_o      (mac_done),
    .filtered_o  (mac_filtered),
    .saturated_o (mac_sat)
  );

  `FIR_ASSERT_NXT(a_fill_bound, is_push, (fill_q != '0) && (fill_q <= n_taps),
                  "Fill count out of bounds after push")
  `FIR_ASSERT_IMP(a_issue_range, state_q == fir_pkg::ST_ISSUE, CntW'(cnt_q) < fill_q,
                  "Tap read beyond held samples")
  `FIR_ASSERT_IMP(a_mac_busy, mac_ctl.vld, state_q != fir_pkg::ST_IDLE,
                  "MAC data while sequencer idle")
  `FIR_ASSERT_NXT(a_out_load, out_load, out_valid_q,
                  "Result load did not raise output valid")

endmodule
